/* hw/rtl/drs_pkg.sv */
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types for the descending rank argsort core: the payloads of the
// input and result channels.
// ----------------------------------------------------------------------------
package drs_pkg;

  // one list entry in arrival order
  typedef struct packed {
    logic signed [31:0] weight;
    logic               last_item;
  } in_item_t;

  // one position of the descending order
  typedef struct packed {
    logic [4:0] item_index;
    logic       last_out;
    logic       overflowed;
  } out_item_t;

endpackage

/* hw/rtl/drs_stream_if.sv */
// ----------------------------------------------------------------------------
// drs_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface drs_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/descending_rank_argsort_core.sv */
// ----------------------------------------------------------------------------
// descending_rank_argsort_core
// Stores a list of signed weights, ranks every entry against all others once
// the last entry arrives, and streams the arrival positions in descending
// weight order with ties kept in arrival order.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                               transaction
//  items     in   weight[31:0] signed, last_item        one list entry
//  results   out  item_index[4:0], last_out, overflowed one sorted position
//
//  load: one entry per cycle into the weight memory.
//  rank: for each of the n stored entries, S_RI and S_WI fetch its weight and
//  S_RJ sweeps the weight memory read port across all n entries.
//  output: S_ORD and S_OLD pass each result via the order memory read port;
//  the last result waits in the output register while the next list loads.
//  reset clears control state only; the memories need no clearing pass.
//  a stalled result channel holds the sequencer in the output phase.
module descending_rank_argsort_core #(
  parameter int MAX_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  drs_stream_if.sink   items,
  drs_stream_if.source results
);
  import drs_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_RI   = 3'd1;
  localparam logic [2:0] S_WI   = 3'd2;
  localparam logic [2:0] S_RJ   = 3'd3;
  localparam logic [2:0] S_ORD  = 3'd4;
  localparam logic [2:0] S_OLD  = 3'd5;

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic          overflow;
  logic [AW-1:0] i_idx;
  logic [AW-1:0] j_idx;
  logic [AW-1:0] jd_idx;
  logic [AW-1:0] k_idx;
  logic [AW-1:0] rank;
  logic signed [31:0] wi;

  logic signed [31:0] weight_mem [MAX_ENTRIES];
  logic [4:0]         order_mem  [MAX_ENTRIES];
  logic signed [31:0] weight_rdata;
  logic [4:0]         order_rdata;

  logic          out_valid;
  out_item_t     out_item;

  logic          in_take;
  logic          out_free;
  logic          hit;
  logic [AW-1:0] rank_next;
  logic [CW-1:0] last_pos;
  logic          j_done;
  logic          i_done;
  logic          k_done;
  logic [AW-1:0] weight_raddr;

  // handshake
  assign items.ready     = (state == S_LOAD);
  assign in_take         = items.valid && items.ready;
  assign results.valid   = out_valid;
  assign results.payload = out_item;
  assign out_free        = !out_valid || results.ready;

  // rank compare: larger weight, or equal weight arriving earlier
  assign hit = (weight_rdata > wi) || ((weight_rdata == wi) && (jd_idx < i_idx));
  assign rank_next = rank + AW'(hit);
  assign last_pos  = count - CW'(1);
  assign j_done    = (CW'(jd_idx) == last_pos);
  assign i_done    = (CW'(i_idx) == last_pos);
  assign k_done    = (CW'(k_idx) == last_pos);
  assign weight_raddr = (state == S_RI) ? i_idx : j_idx;

  // weight memory: written while loading, swept while ranking
  always_ff @(posedge clk) begin
    if (in_take && (count < FULL_COUNT)) begin
      weight_mem[count[AW-1:0]] <= items.payload.weight;
    end
    weight_rdata <= weight_mem[weight_raddr];
  end

  // order memory: written at the rank of each entry, read in output order
  always_ff @(posedge clk) begin
    if ((state == S_RJ) && j_done) begin
      order_mem[rank_next] <= 5'(i_idx);
    end
    order_rdata <= order_mem[k_idx];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      count     <= '0;
      overflow  <= 1'b0;
      i_idx     <= '0;
      j_idx     <= '0;
      jd_idx    <= '0;
      k_idx     <= '0;
      rank      <= '0;
      out_valid <= 1'b0;
    end else begin
      // the output phase reloads the register itself
      if (out_valid && results.ready && (state != S_OLD)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_take) begin
            if (count < FULL_COUNT) begin
              count <= count + CW'(1);
            end else begin
              overflow <= 1'b1;
            end
            if (items.payload.last_item) begin
              i_idx <= '0;
              state <= S_RI;
            end
          end
        end
        S_RI: begin
          j_idx <= '0;
          state <= S_WI;
        end
        S_WI: begin
          wi     <= weight_rdata;
          rank   <= '0;
          jd_idx <= j_idx;
          j_idx  <= j_idx + AW'(1);
          state  <= S_RJ;
        end
        S_RJ: begin
          rank   <= rank_next;
          jd_idx <= j_idx;
          j_idx  <= j_idx + AW'(1);
          if (j_done) begin
            if (i_done) begin
              k_idx <= '0;
              state <= S_ORD;
            end else begin
              i_idx <= i_idx + AW'(1);
              state <= S_RI;
            end
          end
        end
        S_ORD: begin
          state <= S_OLD;
        end
        S_OLD: begin
          if (out_free) begin
            out_valid           <= 1'b1;
            out_item.item_index <= order_rdata;
            out_item.last_out   <= k_done;
            out_item.overflowed <= overflow;
            if (k_done) begin
              count    <= '0;
              overflow <= 1'b0;
              state    <= S_LOAD;
            end else begin
              k_idx <= k_idx + AW'(1);
              state <= S_ORD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // stored count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count above capacity");

  // a rank pass never starts on an empty list
  a_rank_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_RI) |-> (count != '0))
    else $error("rank pass with no stored entries");

  // each result is loaded only from the output phase
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OLD))
    else $error("result raised outside output phase");

  // the final result returns the list to empty
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_OLD && out_free && k_done) |=> (count == '0 && !overflow))
    else $error("list not cleared after final result");

  // the rank written for an entry stays inside the list
  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_RJ && j_done) |-> (CW'(rank_next) < count))
    else $error("rank outside stored list");
`endif

endmodule
